// ----- rtl/lfowg_pkg.sv -----
// ----------------------------------------------------------------------------
// lfowg_pkg
// Shared types, register indexes, waveform codes and constants of the
// low-frequency oscillator.
// ----------------------------------------------------------------------------
package lfowg_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_PHASE_STEP = 3'd0;
	localparam logic [2:0] REG_WAVE_SEL   = 3'd1;
	localparam logic [2:0] REG_SYNC_EN    = 3'd2;
	localparam logic [2:0] REG_RATIO_SEL  = 3'd3;
	localparam logic [2:0] REG_RETRIG_EN  = 3'd4;
	localparam logic [2:0] REG_AMPLITUDE  = 3'd5;
	localparam logic [2:0] REG_OFFSET     = 3'd6;
	localparam logic [2:0] REG_ALPHA      = 3'd7;

	// waveform codes
	localparam logic [2:0] WAVE_SINE     = 3'd0;
	localparam logic [2:0] WAVE_TRIANGLE = 3'd1;
	localparam logic [2:0] WAVE_SQUARE   = 3'd2;
	localparam logic [2:0] WAVE_SAW      = 3'd3;
	localparam logic [2:0] WAVE_RANDOM   = 3'd4;

	// random generator
	localparam logic [31:0] LFSR_SEED = 32'hACE1_ACE1;
	localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;

	// register reset values
	localparam logic [3:0]  RATIO_SEL_RESET = 4'd4;
	localparam logic [16:0] UNITY_Q16       = 17'd65536;

	// configuration register file contents
	typedef struct packed {
		logic [30:0]        phase_step;
		logic [2:0]         wave_sel;
		logic               sync_en;
		logic [3:0]         ratio_sel;
		logic               retrig_en;
		logic [16:0]        amplitude;
		logic signed [17:0] offset;
		logic [16:0]        alpha;
	} cfg_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic phase;
		logic shape;
		logic amp;
		logic smooth;
		logic finish;
	} cmd_t;

	// cycles per beat times 16, selects above nine stay at the last ratio
	function automatic logic [7:0] ratio_x16(input logic [3:0] sel);
		logic [7:0] r;
		case (sel)
			4'd0: r = 8'd1;
			4'd1: r = 8'd2;
			4'd2: r = 8'd4;
			4'd3: r = 8'd8;
			4'd4: r = 8'd16;
			4'd5: r = 8'd32;
			4'd6: r = 8'd48;
			4'd7: r = 8'd64;
			4'd8: r = 8'd96;
			default: r = 8'd128;
		endcase
		return r;
	endfunction

	// one Galois step, right shift
	function automatic logic [31:0] lfsr_step(input logic [31:0] s);
		logic [31:0] n;
		n = {1'b0, s[31:1]};
		if (s[0]) begin
			n = n ^ LFSR_TAPS;
		end
		return n;
	endfunction

	// quarter-wave sine entry, Q30 odd polynomial to x^9, result Q1.16
	function automatic logic [16:0] sine_entry(input int idx, input int qbits);
		longint x;
		longint x2;
		longint t;
		x  = longint'(idx) <<< (30 - qbits);
		x2 = (x * x) / 64'sd1073741824;
		t  = 64'sd172272;
		t  = -64'sd5026995 + (t * x2) / 64'sd1073741824;
		t  = 64'sd85569306 + (t * x2) / 64'sd1073741824;
		t  = -64'sd693598668 + (t * x2) / 64'sd1073741824;
		t  = 64'sd1686629713 + (t * x2) / 64'sd1073741824;
		t  = (t * x) / 64'sd1073741824;
		if (t < 0) begin
			t = 0;
		end
		t = (t + 64'sd8192) / 64'sd16384;
		if (t > 64'sd65536) begin
			t = 64'sd65536;
		end
		return t[16:0];
	endfunction

endpackage

// ----- rtl/lfo_waveform_generator.sv -----
// ----------------------------------------------------------------------------
// lfo_waveform_generator
// Low-frequency oscillator: accumulator or song-position phase, five shapes,
// gain, offset and one-pole smoothing, one result per input sample.
// ----------------------------------------------------------------------------
// Each input transaction yields exactly one output transaction. The shared
// 21x18 multiplier makes three passes (sync phase, gain, smoothing) around one
// registered sine ROM read, and a new item is taken in the cycle a result
// enters the output register, which happens only once the output side is free.
// Configuration writes are taken at any time but belong in idle periods; the
// configuration channel is always ready.
module lfo_waveform_generator #(
	parameter int PHASE_BITS      = 32,
	parameter int SINE_TABLE_BITS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // [0] note_on, [40:1] song_position, zero fill
	input  logic [0:0]  s_tuser,   // [0] transport_present
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [17:0] sample_out, zero fill
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	lfowg_pkg::cfg_t cfg;
	lfowg_pkg::cmd_t cmd;
	logic [17:0]     sample_out;

	// configuration registers
	lfowg_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// sequencer
	lfowg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	// datapath, only the low 20 song position bits reach the phase
	lfowg_dp #(
		.PHASE_BITS      (PHASE_BITS),
		.SINE_TABLE_BITS (SINE_TABLE_BITS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.cfg               (cfg),
		.note_on           (s_tdata[0]),
		.transport_present (s_tuser[0]),
		.song_pos_low      (s_tdata[20:1]),
		.sample_out        (sample_out)
	);

	assign m_tdata = {6'd0, sample_out};

endmodule

// ----- rtl/lfowg_regs.sv -----
// ----------------------------------------------------------------------------
// lfowg_regs
// Configuration register file, written by index over its own channel.
// ----------------------------------------------------------------------------
module lfowg_regs (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [2:0]           cfg_index,
	input  logic [31:0]          cfg_data,
	output lfowg_pkg::cfg_t      cfg
);

	lfowg_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.phase_step <= '0;
			cfg_q.wave_sel   <= lfowg_pkg::WAVE_SINE;
			cfg_q.sync_en    <= 1'b0;
			cfg_q.ratio_sel  <= lfowg_pkg::RATIO_SEL_RESET;
			cfg_q.retrig_en  <= 1'b0;
			cfg_q.amplitude  <= lfowg_pkg::UNITY_Q16;
			cfg_q.offset     <= '0;
			cfg_q.alpha      <= lfowg_pkg::UNITY_Q16;
		end else if (cfg_valid) begin
			case (cfg_index)
				lfowg_pkg::REG_PHASE_STEP: cfg_q.phase_step <= cfg_data[30:0];
				lfowg_pkg::REG_WAVE_SEL:   cfg_q.wave_sel   <= cfg_data[2:0];
				lfowg_pkg::REG_SYNC_EN:    cfg_q.sync_en    <= cfg_data[0];
				lfowg_pkg::REG_RATIO_SEL:  cfg_q.ratio_sel  <= cfg_data[3:0];
				lfowg_pkg::REG_RETRIG_EN:  cfg_q.retrig_en  <= cfg_data[0];
				lfowg_pkg::REG_AMPLITUDE:  cfg_q.amplitude  <= cfg_data[16:0];
				lfowg_pkg::REG_OFFSET:     cfg_q.offset     <= $signed(cfg_data[17:0]);
				lfowg_pkg::REG_ALPHA:      cfg_q.alpha      <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

endmodule

// ----- rtl/lfowg_ctrl.sv -----
// ----------------------------------------------------------------------------
// lfowg_ctrl
// Sequencer for one sample: phase, shape, gain, smoothing and result hand-off.
// ----------------------------------------------------------------------------
module lfowg_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output lfowg_pkg::cmd_t      cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_PHASE  = 3'd1;
	localparam logic [2:0] ST_SHAPE  = 3'd2;
	localparam logic [2:0] ST_AMP    = 3'd3;
	localparam logic [2:0] ST_SMOOTH = 3'd4;
	localparam logic [2:0] ST_FINISH = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_next;
	logic       out_valid_q;
	logic       out_free;
	logic       accept;
	logic       finish;

	// output register can take a new result
	assign out_free = !out_valid_q || m_tready;
	assign finish   = (state_q == ST_FINISH) && out_free;
	assign s_tready = (state_q == ST_IDLE) || finish;
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;

	// datapath commands
	always_comb begin
		cmd        = '0;
		cmd.load   = accept;
		cmd.phase  = (state_q == ST_PHASE);
		cmd.shape  = (state_q == ST_SHAPE);
		cmd.amp    = (state_q == ST_AMP);
		cmd.smooth = (state_q == ST_SMOOTH);
		cmd.finish = finish;
	end

	// next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_next = ST_PHASE;
				end
			end
			ST_PHASE:  state_next = ST_SHAPE;
			ST_SHAPE:  state_next = ST_AMP;
			ST_AMP:    state_next = ST_SMOOTH;
			ST_SMOOTH: state_next = ST_FINISH;
			ST_FINISH: begin
				if (finish) begin
					state_next = accept ? ST_PHASE : ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	// state and output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/lfowg_dp.sv -----
// ----------------------------------------------------------------------------
// lfowg_dp
// Datapath: phase accumulator, sine ROM, shapes, random hold, one shared
// multiplier for sync phase, gain and smoothing, and the result register.
// ----------------------------------------------------------------------------
module lfowg_dp #(
	parameter int PHASE_BITS      = 32,
	parameter int SINE_TABLE_BITS = 10
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lfowg_pkg::cmd_t      cmd,
	input  lfowg_pkg::cfg_t      cfg,
	input  logic                 note_on,
	input  logic                 transport_present,
	input  logic [19:0]          song_pos_low,
	output logic [17:0]          sample_out
);

	localparam int QB = SINE_TABLE_BITS - 2;
	localparam int QN = 1 << QB;

	// captured item
	logic               note_q;
	logic               transport_q;
	logic [19:0]        pos_q;

	// oscillator state
	logic [PHASE_BITS-1:0] phase_accum_q;
	logic [PHASE_BITS-1:0] prev_phase_q;
	logic                  hold_invalid_q;
	logic [31:0]           lfsr_q;
	logic signed [16:0]    held_random_q;
	logic signed [18:0]    smooth_q;

	// working registers
	logic [PHASE_BITS-1:0] p_q;
	logic [16:0]           rom_q;
	logic signed [38:0]    mul_q;
	logic [17:0]           out_q;

	// quarter-wave sine table
	logic [16:0] sine_rom [QN+1];

	for (genvar g = 0; g <= QN; g++) begin : g_rom
		assign sine_rom[g] = lfowg_pkg::sine_entry(g, QB);
	end

	// saturated gains
	logic [16:0] amp_sat;
	logic [16:0] alpha_sat;

	assign amp_sat   = (cfg.amplitude[16] && |cfg.amplitude[15:0]) ? lfowg_pkg::UNITY_Q16
	                                                               : cfg.amplitude;
	assign alpha_sat = (cfg.alpha[16] && |cfg.alpha[15:0]) ? lfowg_pkg::UNITY_Q16 : cfg.alpha;

	// phase selection
	logic                  use_sync;
	logic [47:0]           sync_wide;
	logic [PHASE_BITS-1:0] p;
	logic [SINE_TABLE_BITS-1:0] sine_idx;
	logic [QB-1:0]         sine_j;
	logic [QB:0]           rom_addr;

	assign use_sync  = cfg.sync_en && transport_q;
	assign sync_wide = {mul_q[19:0], 28'd0};
	assign p         = use_sync ? sync_wide[47 -: PHASE_BITS] : phase_accum_q;
	assign sine_idx  = p[PHASE_BITS-1 -: SINE_TABLE_BITS];
	assign sine_j    = sine_idx[QB-1:0];
	assign rom_addr  = sine_idx[QB] ? ((QB+1)'(QN) - {1'b0, sine_j}) : {1'b0, sine_j};

	// random draw
	logic [31:0] lfsr_next;
	logic        redraw;

	assign lfsr_next = lfowg_pkg::lfsr_step(lfsr_q);
	assign redraw    = hold_invalid_q || (p < prev_phase_q);

	// raw shape from the registered phase
	logic [15:0]        p16;
	logic [18:0]        tri_down;
	logic signed [17:0] raw;

	assign p16      = p_q[PHASE_BITS-1 -: 16];
	assign tri_down = 19'd196608 - {1'b0, p16, 2'b00};

	always_comb begin
		case (cfg.wave_sel)
			lfowg_pkg::WAVE_SINE: begin
				raw = p_q[PHASE_BITS-1] ? -$signed({1'b0, rom_q}) : $signed({1'b0, rom_q});
			end
			lfowg_pkg::WAVE_TRIANGLE: begin
				raw = p16[15] ? $signed(tri_down[17:0])
				              : $signed({1'b0, p16[14:0], 2'b00} - 18'd65536);
			end
			lfowg_pkg::WAVE_SQUARE: begin
				raw = p16[15] ? -18'sd65536 : 18'sd65536;
			end
			lfowg_pkg::WAVE_SAW: begin
				raw = $signed({1'b0, p16, 1'b0} - 18'd65536);
			end
			lfowg_pkg::WAVE_RANDOM: begin
				raw = {held_random_q[16], held_random_q};
			end
			default: raw = '0;
		endcase
	end

	// gain rounding, offset and smoother difference
	logic signed [38:0] rnd_mul;
	logic signed [22:0] mul_term;
	logic signed [19:0] target;
	logic signed [20:0] diff;

	assign rnd_mul  = mul_q + 39'sd32768;
	assign mul_term = $signed(rnd_mul[38:16]);
	assign target   = $signed(mul_term[19:0]) + {{2{cfg.offset[17]}}, cfg.offset};
	assign diff     = {target[19], target} - {{2{smooth_q[18]}}, smooth_q};

	// smoother output with saturation
	logic signed [22:0] y_sum;
	logic signed [18:0] y_sat;
	logic [17:0]        y_out;

	assign y_sum = {{4{smooth_q[18]}}, smooth_q} + mul_term;

	always_comb begin
		if (y_sum > 23'sd262143) begin
			y_sat = 19'sd262143;
		end else if (y_sum < -23'sd262144) begin
			y_sat = -19'sd262144;
		end else begin
			y_sat = y_sum[18:0];
		end
		if (y_sat > 19'sd131071) begin
			y_out = 18'h1FFFF;
		end else if (y_sat < -19'sd131072) begin
			y_out = 18'h20000;
		end else begin
			y_out = y_sat[17:0];
		end
	end

	// shared multiplier operands
	logic signed [20:0] mul_a;
	logic signed [17:0] mul_b;

	always_comb begin
		if (cmd.phase) begin
			mul_a = $signed({1'b0, pos_q});
			mul_b = $signed({10'd0, lfowg_pkg::ratio_x16(cfg.ratio_sel)});
		end else if (cmd.amp) begin
			mul_a = {{3{raw[17]}}, raw};
			mul_b = $signed({1'b0, amp_sat});
		end else begin
			mul_a = diff;
			mul_b = $signed({1'b0, alpha_sat});
		end
	end

	// phase step, zero-extended and cut to accumulator width at the add
	logic [PHASE_BITS+30:0] step_wide;

	assign step_wide = {{PHASE_BITS{1'b0}}, cfg.phase_step};

	// item capture, multiplier, shape and result registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			note_q      <= note_on;
			transport_q <= transport_present;
			pos_q       <= song_pos_low;
		end
		if (cmd.phase || cmd.amp || cmd.smooth) begin
			mul_q <= mul_a * mul_b;
		end
		if (cmd.shape) begin
			p_q   <= p;
			rom_q <= sine_rom[rom_addr];
		end
		if (cmd.finish) begin
			out_q <= y_out;
		end
	end

	// oscillator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_accum_q  <= '0;
			prev_phase_q   <= '0;
			hold_invalid_q <= 1'b1;
			lfsr_q         <= lfowg_pkg::LFSR_SEED;
			held_random_q  <= '0;
			smooth_q       <= '0;
		end else begin
			// retrigger on note-on
			if (cmd.phase && note_q && cfg.retrig_en) begin
				phase_accum_q  <= '0;
				hold_invalid_q <= 1'b1;
			end
			// sample and hold random
			if (cmd.shape && (cfg.wave_sel == lfowg_pkg::WAVE_RANDOM)) begin
				prev_phase_q <= p;
				if (redraw) begin
					lfsr_q         <= lfsr_next;
					held_random_q  <= $signed(lfsr_next[16:0]);
					hold_invalid_q <= 1'b0;
				end
			end
			// end of item
			if (cmd.finish) begin
				smooth_q <= y_sat;
				if (!cfg.sync_en) begin
					phase_accum_q <= phase_accum_q + step_wide[PHASE_BITS-1:0];
				end
			end
		end
	end

	assign sample_out = out_q;

endmodule
